// ----- design/out_of_band_segment_filter_macros.svh -----
// assertion macros shared by the segment filter rtl
`ifndef OUT_OF_BAND_SEGMENT_FILTER_MACROS_SVH
`define OUT_OF_BAND_SEGMENT_FILTER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define OOBSF_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("segment filter assertion failed");
// next-cycle implication
`define OOBSF_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("segment filter assertion failed");
`else
`define OOBSF_ASSERT_IMP(label, clk, rstn, ante, cons)
`define OOBSF_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

// ----- design/oobsf_pkg.sv -----
// shared types, constants and framing functions of the segment filter
package oobsf_pkg;

    localparam int HOLD_DEPTH_DEF = 48;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [7:0] TN_IAC       = 8'hFF;
    localparam logic [7:0] TN_SB        = 8'hFA;
    localparam logic [7:0] TN_SE        = 8'hF0;
    localparam logic [7:0] ESC_BYTE     = 8'h1B;
    localparam logic [7:0] BRACKET_BYTE = 8'h5B;
    localparam logic [7:0] MXP_END_BYTE = 8'h7A;

    localparam logic [7:0] PROTO_TELNET = 8'd0;
    localparam logic [7:0] PROTO_GMCP   = 8'd201;
    localparam logic [7:0] PROTO_MSDP   = 8'd69;
    localparam logic [7:0] PROTO_MXP    = 8'd27;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROTOCOL_ID  = 1'b0,
        REG_EXTRACT_MODE = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        STAT_OK             = 2'd0,
        STAT_UNSUPPORTED    = 2'd1,
        STAT_NONE_EXTRACTED = 2'd2,
        STAT_OVERFLOW       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SRC_PATTERN = 2'd0,
        SRC_BYTE    = 2'd1,
        SRC_HELD    = 2'd2,
        SRC_STATUS  = 2'd3
    } out_sel_t;

    typedef struct packed {
        logic     accept;
        logic     load_out;
        out_sel_t sel;
        logic     idx_clr;
        logic     idx_inc;
        logic     ram_rd;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic new_a;
        logic new_b;
        logic new_c;
        logic new_h;
        logic new_s;
        logic has_b;
        logic has_c;
        logic has_h;
        logic has_s;
        logic a_last;
        logic c_last;
        logic h_last;
    } sts_t;

    // start pattern length, zero for an unsupported id
    function automatic logic [1:0] pattern_len(input logic [7:0] proto);
        logic [1:0] len;
        if (proto == PROTO_MXP || proto == PROTO_TELNET) begin
            len = 2'd2;
        end else if (proto == PROTO_GMCP || proto == PROTO_MSDP) begin
            len = 2'd3;
        end else begin
            len = 2'd0;
        end
        return len;
    endfunction

    function automatic logic [7:0] start_byte(input logic [7:0] proto, input logic [1:0] pos);
        logic [7:0] b;
        if (proto == PROTO_MXP) begin
            b = (pos == 2'd0) ? ESC_BYTE : BRACKET_BYTE;
        end else begin
            case (pos)
                2'd0: begin
                    b = TN_IAC;
                end
                2'd1: begin
                    b = TN_SB;
                end
                default: begin
                    b = proto;
                end
            endcase
        end
        return b;
    endfunction

endpackage

// ----- design/oobsf_ram.sv -----
// generic single-port-write ram with registered read
module oobsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// ----- design/oobsf_dp.sv -----
// datapath: framing search, string state, hold ram, emission plan and output register
module oobsf_dp #(
    parameter int HOLD_DEPTH = oobsf_pkg::HOLD_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rstn,
    input  logic                             cfg_wr_en,
    input  logic [oobsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [oobsf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_is_final,
    input  logic                             m_ready,
    input  oobsf_pkg::cmd_t                  cmd,
    output oobsf_pkg::sts_t                  sts,
    output logic                             m_valid,
    output logic [7:0]                       m_out_byte,
    output logic                             m_has_byte,
    output logic                             m_end_of_string,
    output logic [1:0]                       m_status
);
    import oobsf_pkg::*;

    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int AW = $clog2(HOLD_DEPTH);

    typedef enum logic [1:0] {
        EM_NONE    = 2'd0,
        EM_HELD    = 2'd1,
        EM_DROPPED = 2'd2
    } end_match_t;

    // configuration and string state
    logic [7:0]  proto_reg;
    logic        extract_reg;
    logic        inside_reg, inside_next;
    logic [1:0]  smc_reg, smc_next;
    end_match_t  emc_reg, emc_next;
    logic [CW-1:0] held_cnt_reg, held_cnt_next;
    logic        extracted_reg, extracted_next;
    logic        ovf_reg, ovf_next;

    // emission plan of the accepted transaction
    logic [7:0]    byte_reg;
    logic [1:0]    ka_reg, ka_next;
    logic          kb_reg, kb_next;
    logic [1:0]    kc_reg, kc_next;
    logic [CW-1:0] n_reg, n_next;
    logic          fin_reg;
    status_t       stat_reg, stat_next;

    logic [CW-1:0] idx_reg;

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_has_reg;
    logic          out_eos_reg;
    status_t       out_stat_reg;

    logic [1:0]    slen;
    logic          elen_one;
    logic [1:0]    c, c_inc;
    logic          do_hold, do_complete, hold_ok, wr_step;
    logic [CW-1:0] n_done;
    logic [1:0]    ka_m1, kc_m1;
    logic [7:0]    ram_rdata;

    assign slen     = pattern_len(proto_reg);
    assign elen_one = (proto_reg == PROTO_MXP);
    assign hold_ok  = held_cnt_reg < CW'(HOLD_DEPTH);
    assign c        = (smc_reg >= slen) ? 2'd0 : smc_reg;
    assign c_inc    = c + 2'd1;
    assign n_done   = (emc_reg == EM_HELD && held_cnt_reg != '0) ?
                      held_cnt_reg - CW'(1) : held_cnt_reg;

    always_comb begin
        inside_next    = inside_reg;
        smc_next       = smc_reg;
        emc_next       = emc_reg;
        held_cnt_next  = held_cnt_reg;
        extracted_next = extracted_reg;
        ovf_next       = ovf_reg;
        ka_next        = 2'd0;
        kb_next        = 1'b0;
        kc_next        = 2'd0;
        n_next         = '0;
        stat_next      = STAT_OK;
        do_hold        = 1'b0;
        do_complete    = 1'b0;
        wr_step        = 1'b0;

        if (slen != 2'd0) begin
            if (!inside_reg) begin
                if (s_data_byte == start_byte(proto_reg, c)) begin
                    if (c_inc == slen) begin
                        inside_next   = 1'b1;
                        emc_next      = EM_NONE;
                        held_cnt_next = '0;
                        smc_next      = 2'd0;
                    end else begin
                        smc_next = c_inc;
                    end
                end else begin
                    if (!extract_reg) begin
                        ka_next = c;
                    end
                    if (s_data_byte == start_byte(proto_reg, 2'd0)) begin
                        smc_next = 2'd1;
                    end else begin
                        smc_next = 2'd0;
                        kb_next  = !extract_reg;
                    end
                end
            end else if (elen_one) begin
                if (s_data_byte == MXP_END_BYTE) begin
                    do_complete = 1'b1;
                end else begin
                    do_hold = 1'b1;
                end
            end else begin
                if (emc_reg != EM_NONE && s_data_byte == TN_SE) begin
                    do_complete = 1'b1;
                end else begin
                    do_hold = 1'b1;
                end
            end
        end

        if (do_hold) begin
            if (hold_ok) begin
                wr_step       = 1'b1;
                held_cnt_next = held_cnt_reg + CW'(1);
            end else begin
                ovf_next = 1'b1;
            end
            if (!elen_one) begin
                if (s_data_byte == TN_IAC) begin
                    emc_next = hold_ok ? EM_HELD : EM_DROPPED;
                end else begin
                    emc_next = EM_NONE;
                end
            end
        end

        if (do_complete) begin
            if (extract_reg) begin
                n_next = n_done;
            end
            extracted_next = 1'b1;
            inside_next    = 1'b0;
            smc_next       = 2'd0;
            emc_next       = EM_NONE;
            held_cnt_next  = '0;
        end

        if (s_is_final) begin
            if (slen != 2'd0 && !extract_reg) begin
                if (inside_next) begin
                    kc_next = slen;
                    n_next  = held_cnt_next;
                end else begin
                    kc_next = smc_next;
                end
            end
            if (slen == 2'd0) begin
                stat_next = STAT_UNSUPPORTED;
            end else if (ovf_next) begin
                stat_next = STAT_OVERFLOW;
            end else if (extract_reg && !extracted_next) begin
                stat_next = STAT_NONE_EXTRACTED;
            end else begin
                stat_next = STAT_OK;
            end
            inside_next    = 1'b0;
            smc_next       = 2'd0;
            emc_next       = EM_NONE;
            held_cnt_next  = '0;
            extracted_next = 1'b0;
            ovf_next       = 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            proto_reg     <= PROTO_TELNET;
            extract_reg   <= 1'b0;
            inside_reg    <= 1'b0;
            smc_reg       <= 2'd0;
            emc_reg       <= EM_NONE;
            held_cnt_reg  <= '0;
            extracted_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_PROTOCOL_ID: begin
                    proto_reg <= cfg_wr_data[7:0];
                end
                REG_EXTRACT_MODE: begin
                    extract_reg <= cfg_wr_data[0];
                end
                default: begin
                    proto_reg <= proto_reg;
                end
            endcase
            inside_reg    <= 1'b0;
            smc_reg       <= 2'd0;
            emc_reg       <= EM_NONE;
            held_cnt_reg  <= '0;
            extracted_reg <= 1'b0;
            ovf_reg       <= 1'b0;
        end else if (cmd.accept) begin
            inside_reg    <= inside_next;
            smc_reg       <= smc_next;
            emc_reg       <= emc_next;
            held_cnt_reg  <= held_cnt_next;
            extracted_reg <= extracted_next;
            ovf_reg       <= ovf_next;
        end
    end

    // plan registers
    always_ff @(posedge clk) begin
        if (!rstn) begin
            ka_reg  <= 2'd0;
            kb_reg  <= 1'b0;
            kc_reg  <= 2'd0;
            n_reg   <= '0;
            fin_reg <= 1'b0;
        end else if (cmd.accept) begin
            ka_reg  <= ka_next;
            kb_reg  <= kb_next;
            kc_reg  <= kc_next;
            n_reg   <= n_next;
            fin_reg <= s_is_final;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.accept) begin
            byte_reg <= s_data_byte;
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            idx_reg <= '0;
        end else if (cmd.idx_clr) begin
            idx_reg <= '0;
        end else if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
    end

    oobsf_ram #(
        .WIDTH(8),
        .DEPTH(HOLD_DEPTH)
    ) u_hold_ram (
        .clk    (clk),
        .wr_en  (cmd.accept && wr_step),
        .wr_addr(held_cnt_reg[AW-1:0]),
        .wr_data(s_data_byte),
        .rd_en  (cmd.ram_rd),
        .rd_addr(idx_reg[AW-1:0]),
        .rd_data(ram_rdata)
    );

    // output register
    always_ff @(posedge clk) begin
        if (!rstn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load_out) begin
            case (cmd.sel)
                SRC_PATTERN: begin
                    out_byte_reg <= start_byte(proto_reg, idx_reg[1:0]);
                    out_has_reg  <= 1'b1;
                    out_eos_reg  <= 1'b0;
                    out_stat_reg <= STAT_OK;
                end
                SRC_BYTE: begin
                    out_byte_reg <= byte_reg;
                    out_has_reg  <= 1'b1;
                    out_eos_reg  <= 1'b0;
                    out_stat_reg <= STAT_OK;
                end
                SRC_HELD: begin
                    out_byte_reg <= ram_rdata;
                    out_has_reg  <= 1'b1;
                    out_eos_reg  <= 1'b0;
                    out_stat_reg <= STAT_OK;
                end
                default: begin
                    out_byte_reg <= 8'd0;
                    out_has_reg  <= 1'b0;
                    out_eos_reg  <= 1'b1;
                    out_stat_reg <= stat_reg;
                end
            endcase
        end
    end

    assign ka_m1 = ka_reg - 2'd1;
    assign kc_m1 = kc_reg - 2'd1;

    always_comb begin
        sts.out_free = !out_valid_reg || m_ready;
        sts.new_a    = (ka_next != 2'd0);
        sts.new_b    = kb_next;
        sts.new_c    = (kc_next != 2'd0);
        sts.new_h    = (n_next != '0);
        sts.new_s    = s_is_final;
        sts.has_b    = kb_reg;
        sts.has_c    = (kc_reg != 2'd0);
        sts.has_h    = (n_reg != '0);
        sts.has_s    = fin_reg;
        sts.a_last   = (idx_reg == CW'(ka_m1));
        sts.c_last   = (idx_reg == CW'(kc_m1));
        sts.h_last   = (idx_reg == n_reg - CW'(1));
    end

    assign m_valid         = out_valid_reg;
    assign m_out_byte      = out_byte_reg;
    assign m_has_byte      = out_has_reg;
    assign m_end_of_string = out_eos_reg;
    assign m_status        = out_stat_reg;
endmodule

// ----- design/oobsf_ctrl.sv -----
// controller: sequences the result transactions of one accepted input
module oobsf_ctrl (
    input  logic            clk,
    input  logic            rstn,
    input  logic            s_valid,
    output logic            s_ready,
    input  oobsf_pkg::sts_t sts,
    output oobsf_pkg::cmd_t cmd
);
    import oobsf_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_PRE_A    = 7'b0000010,
        ST_BYTE_B   = 7'b0000100,
        ST_PRE_C    = 7'b0001000,
        ST_HOLD_RD  = 7'b0010000,
        ST_HOLD_OUT = 7'b0100000,
        ST_STATUS   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // first phase with work left
    function automatic state_t pick(input logic a, input logic b, input logic c,
                                    input logic h, input logic s);
        state_t st;
        if (a) begin
            st = ST_PRE_A;
        end else if (b) begin
            st = ST_BYTE_B;
        end else if (c) begin
            st = ST_PRE_C;
        end else if (h) begin
            st = ST_HOLD_RD;
        end else if (s) begin
            st = ST_STATUS;
        end else begin
            st = ST_IDLE;
        end
        return st;
    endfunction

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SRC_PATTERN;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept  = 1'b1;
                    cmd.idx_clr = 1'b1;
                    state_next  = pick(sts.new_a, sts.new_b, sts.new_c, sts.new_h, sts.new_s);
                end
            end
            ST_PRE_A: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.sel      = SRC_PATTERN;
                    if (sts.a_last) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = pick(1'b0, sts.has_b, sts.has_c, sts.has_h, sts.has_s);
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_BYTE_B: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.sel      = SRC_BYTE;
                    state_next   = pick(1'b0, 1'b0, sts.has_c, sts.has_h, sts.has_s);
                end
            end
            ST_PRE_C: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.sel      = SRC_PATTERN;
                    if (sts.c_last) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = pick(1'b0, 1'b0, 1'b0, sts.has_h, sts.has_s);
                    end else begin
                        cmd.idx_inc = 1'b1;
                    end
                end
            end
            ST_HOLD_RD: begin
                cmd.ram_rd = 1'b1;
                state_next = ST_HOLD_OUT;
            end
            ST_HOLD_OUT: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.sel      = SRC_HELD;
                    if (sts.h_last) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = pick(1'b0, 1'b0, 1'b0, 1'b0, sts.has_s);
                    end else begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_HOLD_RD;
                    end
                end
            end
            ST_STATUS: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.sel      = SRC_STATUS;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
endmodule

// ----- design/out_of_band_segment_filter.sv -----
// top level of the out-of-band segment filter
// Byte-stream filter for telnet subnegotiation (IAC SB [id] ... IAC SE) and MXP (ESC [ ... z)
// segments, selected by protocol_id; extract_mode picks payload-only output instead of
// removal. One input transaction is in flight at a time. A byte that produces no result is
// only accepted; otherwise, after accepting it, the controller emits its start-pattern and
// pass-through bytes, the payload bytes replayed from the hold ram (registered read, then
// output load) and the end-of-string status; m_ready stalls can hold back each output load.
// A new input is taken while the last result still waits in the output register. The hold
// ram needs no clearing after reset.
`include "out_of_band_segment_filter_macros.svh"

module out_of_band_segment_filter #(
    parameter int HOLD_DEPTH = oobsf_pkg::HOLD_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [oobsf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [oobsf_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_data_byte,
    input  logic                             s_is_final,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_out_byte,
    output logic                             m_has_byte,
    output logic                             m_end_of_string,
    output logic [1:0]                       m_status
);
    import oobsf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    oobsf_ctrl u_ctrl (
        .clk    (aclk),
        .rstn   (aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    oobsf_dp #(
        .HOLD_DEPTH(HOLD_DEPTH)
    ) u_dp (
        .clk            (aclk),
        .rstn           (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_data_byte    (s_data_byte),
        .s_is_final     (s_is_final),
        .m_ready        (m_ready),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_out_byte     (m_out_byte),
        .m_has_byte     (m_has_byte),
        .m_end_of_string(m_end_of_string),
        .m_status       (m_status)
    );

    // a pending result is never overwritten
    `OOBSF_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.load_out, sts.out_free)
    // a final byte always leaves a status transaction to send
    `OOBSF_ASSERT_NXT(a_final_blocks_input, aclk, aresetn, s_valid && s_ready && s_is_final, !s_ready)
endmodule
